// ===== src/gqdp_pkg.sv =====
// ----------------------------------------------------------------------------
// gqdp_pkg
// shared types, register codes and fp32 arithmetic for the quantised dot product
// ----------------------------------------------------------------------------
package gqdp_pkg;

    localparam int ACCUM_LANES_DEF = 4;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_CODE_BITS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMMETRIC = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FMT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACT_FMT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_FMT   = 3'd4;

    localparam logic [1:0] SCALE_BF16 = 2'd0;
    localparam logic [1:0] SCALE_F16  = 2'd1;
    localparam logic [1:0] SCALE_E8M0 = 2'd2;
    localparam logic [1:0] SCALE_E4M3 = 2'd3;

    localparam logic [1:0] FMT_FP32 = 2'd0;
    localparam logic [1:0] FMT_F16  = 2'd1;
    localparam logic [1:0] FMT_BF16 = 2'd2;

    localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] FP_QNAN        = 32'h7FC0_0000;

    typedef struct packed {
        logic [3:0] code_bits;
        logic       symmetric_mode;
        logic [1:0] scale_format;
        logic [1:0] activation_format;
        logic [1:0] output_format;
    } cfg_t;

    typedef struct packed {
        logic [31:0] cval;
        logic [31:0] scale;
        logic [31:0] bias;
        logic [31:0] act;
        logic        last;
    } dec_t;

    function automatic int level_count(input int n, input int k);
        int c;
        c = n;
        for (int j = 0; j < k; j++)
        begin
            c = (c + 1) >> 1;
        end
        return c;
    endfunction

    // value = m * 2^x, m nonzero, rounded to nearest even
    function automatic logic [31:0] fp_round(input logic s, input logic [51:0] m,
                                             input logic signed [11:0] x);
        logic [5:0]         lead;
        logic signed [11:0] sh;
        logic signed [11:0] smin;
        logic signed [11:0] e;
        logic signed [11:0] ef;
        logic [63:0]        mm;
        logic [63:0]        mask;
        logic [24:0]        q;
        logic               rnd;
        logic               stk;
        logic [31:0]        r;
        lead = '0;
        for (int i = 0; i < 52; i++)
        begin
            if (m[i])
                lead = 6'(i);
        end
        sh = $signed({6'b0, lead}) - 12'sd23;
        smin = -12'sd149 - x;
        if (sh < smin)
            sh = smin;
        mm = {12'b0, m};
        rnd = 1'b0;
        stk = 1'b0;
        mask = '0;
        if (sh <= 0)
        begin
            q = 25'(mm << 6'(-sh));
        end
        else if (sh >= 12'sd53)
        begin
            q = '0;
            stk = |m;
        end
        else
        begin
            q = 25'(mm >> sh[5:0]);
            rnd = mm[6'(sh - 12'sd1)];
            mask = (64'd1 << 6'(sh - 12'sd1)) - 64'd1;
            stk = |(mm & mask);
        end
        if (rnd && (stk || q[0]))
            q = q + 25'd1;
        e = x + sh;
        if (q[24])
        begin
            q = q >> 1;
            e = e + 12'sd1;
        end
        ef = e + 12'sd150;
        if (!q[23])
            r = {s, 8'd0, q[22:0]};
        else if (ef >= 12'sd255)
            r = {s, 8'hFF, 23'd0};
        else
            r = {s, ef[7:0], q[22:0]};
        return r;
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic               s;
        logic [7:0]         ea;
        logic [7:0]         eb;
        logic               an;
        logic               bn;
        logic               az;
        logic               bz;
        logic               ai;
        logic               bi;
        logic [47:0]        p;
        logic signed [11:0] x;
        logic [31:0]        r;
        s  = a[31] ^ b[31];
        an = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        bn = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        ai = (a[30:23] == 8'hFF) && (a[22:0] == '0);
        bi = (b[30:23] == 8'hFF) && (b[22:0] == '0);
        az = (a[30:0] == '0);
        bz = (b[30:0] == '0);
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        p  = {a[30:23] != 8'd0, a[22:0]} * {b[30:23] != 8'd0, b[22:0]};
        x  = $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd300;
        if (an)
            r = a | 32'h0040_0000;
        else if (bn)
            r = b | 32'h0040_0000;
        else if ((ai && bz) || (bi && az))
            r = FP_DEFAULT_NAN;
        else if (ai || bi)
            r = {s, 8'hFF, 23'd0};
        else if (az || bz)
            r = {s, 31'd0};
        else
            r = fp_round(s, {4'b0, p}, x);
        return r;
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic        an;
        logic        bn;
        logic        ai;
        logic        bi;
        logic        swap;
        logic [31:0] big;
        logic [31:0] sml;
        logic [7:0]  be;
        logic [7:0]  se;
        logic [7:0]  d;
        logic [51:0] bm;
        logic [51:0] sm0;
        logic [51:0] smv;
        logic [51:0] sum;
        logic        stk;
        logic [31:0] r;
        an = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        bn = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        ai = (a[30:23] == 8'hFF) && (a[22:0] == '0);
        bi = (b[30:23] == 8'hFF) && (b[22:0] == '0);
        swap = (a[30:0] < b[30:0]);
        big = swap ? b : a;
        sml = swap ? a : b;
        be = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        se = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d  = be - se;
        bm  = {2'b0, big[30:23] != 8'd0, big[22:0], 26'd0};
        sm0 = {2'b0, sml[30:23] != 8'd0, sml[22:0], 26'd0};
        if (d >= 8'd50)
        begin
            smv = '0;
            stk = |sm0;
        end
        else
        begin
            smv = sm0 >> d;
            stk = |(sm0 & ((52'd1 << d) - 52'd1));
        end
        smv[0] = smv[0] | stk;
        if (big[31] == sml[31])
            sum = bm + smv;
        else
            sum = bm - smv;
        if (an)
            r = a | 32'h0040_0000;
        else if (bn)
            r = b | 32'h0040_0000;
        else if (ai && bi && (a[31] != b[31]))
            r = FP_DEFAULT_NAN;
        else if (ai)
            r = a;
        else if (bi)
            r = b;
        else if ((a[30:0] == '0) && (b[30:0] == '0))
            r = {a[31] & b[31], 31'd0};
        else if (sum == '0)
            r = 32'd0;
        else
            r = fp_round(big[31], sum, $signed({4'b0, be}) - 12'sd176);
        return r;
    endfunction

    function automatic logic [31:0] half_to_f(input logic [15:0] h);
        logic [31:0] r;
        if (h[14:10] == 5'd0)
            r = (h[9:0] == '0) ? {h[15], 31'd0}
                               : fp_round(h[15], {42'b0, h[9:0]}, -12'sd24);
        else if (h[14:10] == 5'h1F)
            r = {h[15], 8'hFF, h[9:0], 13'd0};
        else
            r = {h[15], {3'b0, h[14:10]} + 8'd112, h[9:0], 13'd0};
        return r;
    endfunction

    function automatic logic [31:0] e4m3_to_f(input logic [7:0] b);
        logic [31:0] r;
        if ((b[6:3] == 4'hF) && (b[2:0] == 3'h7))
            r = {b[7], FP_QNAN[30:0]};
        else if (b[6:3] == 4'd0)
            r = (b[2:0] == '0) ? {b[7], 31'd0}
                               : fp_round(b[7], {49'b0, b[2:0]}, -12'sd9);
        else
            r = {b[7], {4'b0, b[6:3]} + 8'd120, b[2:0], 20'd0};
        return r;
    endfunction

    function automatic logic [31:0] decode_scale(input logic [1:0] fmt, input logic [15:0] w);
        logic [31:0] r;
        case (fmt)
            SCALE_BF16: r = {w, 16'd0};
            SCALE_F16:  r = half_to_f(w);
            SCALE_E8M0:
            begin
                if (w[7:0] == 8'hFF)
                    r = FP_QNAN;
                else if (w[7:0] == 8'd0)
                    r = 32'h0040_0000;
                else
                    r = {1'b0, w[7:0], 23'd0};
            end
            default:    r = e4m3_to_f(w[7:0]);
        endcase
        return r;
    endfunction

    function automatic logic [31:0] decode_act(input logic [1:0] fmt, input logic [31:0] w);
        logic [31:0] r;
        case (fmt)
            FMT_F16:  r = half_to_f(w[15:0]);
            FMT_BF16: r = {w[15:0], 16'd0};
            default:  r = w;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] code_to_f(input logic signed [8:0] c);
        logic [8:0]  mag;
        logic [31:0] r;
        mag = c[8] ? 9'(-c) : 9'(c);
        if (c == '0)
            r = 32'd0;
        else
            r = fp_round(c[8], {43'b0, mag}, 12'sd0);
        return r;
    endfunction

    function automatic logic [15:0] f_to_bf16(input logic [31:0] u);
        logic [31:0] t;
        if (u[30:0] > 31'h7F80_0000)
            t = (u >> 16) | 32'h40;
        else
            t = (u + 32'h7FFF + {31'd0, u[16]}) >> 16;
        return t[15:0];
    endfunction

    function automatic logic [15:0] f_to_half(input logic [31:0] u);
        logic [15:0] s;
        logic [31:0] a;
        logic [7:0]  ex;
        logic [7:0]  sh;
        logic [23:0] mant;
        logic [23:0] q;
        logic [23:0] rem;
        logic [23:0] half;
        logic [31:0] h;
        logic [15:0] r;
        s = {u[31], 15'd0};
        a = {1'b0, u[30:0]};
        ex = a[30:23];
        mant = {1'b1, a[22:0]};
        sh = 8'd126 - ex;
        h = (a >> 13) - 32'h1C000;
        q = '0;
        rem = '0;
        half = '0;
        if (a > 32'h7F80_0000)
            r = s | 16'h7E00 | {6'd0, a[22:13]};
        else if (a >= 32'h477F_F000)
            r = s | 16'h7C00;
        else if (a < 32'h3880_0000)
        begin
            if (sh > 8'd24)
                r = s;
            else
            begin
                q = mant >> sh;
                rem = mant & ((24'd1 << sh) - 24'd1);
                half = 24'd1 << (sh - 8'd1);
                if ((rem > half) || ((rem == half) && q[0]))
                    q = q + 24'd1;
                r = s | q[15:0];
            end
        end
        else
        begin
            if ((a[12:0] > 13'h1000) || ((a[12:0] == 13'h1000) && h[0]))
                h = h + 32'd1;
            r = s | h[15:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] encode_out(input logic [1:0] fmt, input logic [31:0] v);
        logic [31:0] r;
        case (fmt)
            FMT_F16:  r = {16'd0, f_to_half(v)};
            FMT_BF16: r = {16'd0, f_to_bf16(v)};
            default:  r = v;
        endcase
        return r;
    endfunction

endpackage

// ===== src/grouped_quant_dot_product.sv =====
// ----------------------------------------------------------------------------
// grouped_quant_dot_product
// one row of a group-quantised matrix times a vector, fp32 accumulation
// ----------------------------------------------------------------------------
// Accepts one weight element per cycle and keeps doing so while a finished row
// result waits at the output. An element passes decode, code-times-scale, bias
// add and weight-times-activation stages, then is added into one of
// ACCUM_LANES fp32 partial sums in a combinational adder. After its last
// element is accepted, the result of a row passes those stages, the row
// snapshot, the reduction levels, the output encode register and the output
// register. A refused result waits in the output register; the pipeline only
// holds when a second result reaches its end before the first is taken.
// Configuration is taken at any time through cfg_we and must only change while
// no row is in flight.
// ----------------------------------------------------------------------------
module grouped_quant_dot_product
#(
    parameter int ACCUM_LANES = gqdp_pkg::ACCUM_LANES_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // code[7:0], scale_raw[23:8], bias_raw[39:24], activation_raw[71:40]
    input  logic [gqdp_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // dot_raw[31:0]
    output logic [gqdp_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                              cfg_we,
    input  logic [gqdp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gqdp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import gqdp_pkg::*;

    cfg_t                cfg_reg;
    logic                adv;
    logic                dec_valid;
    dec_t                dec;
    logic                prod_valid;
    logic [31:0]         prod;
    logic                prod_last;
    logic                pipe_valid;
    logic [31:0]         pipe_data;
    logic                res_free;
    logic                res_valid_reg;
    logic [M_DATA_W-1:0] res_data_reg;

    assign res_free = !res_valid_reg || m_tready;
    assign adv = res_free || !pipe_valid;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_bits         <= 4'd4;
            cfg_reg.symmetric_mode    <= 1'b1;
            cfg_reg.scale_format      <= SCALE_BF16;
            cfg_reg.activation_format <= FMT_FP32;
            cfg_reg.output_format     <= FMT_FP32;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CODE_BITS: cfg_reg.code_bits         <= cfg_data;
                REG_SYMMETRIC: cfg_reg.symmetric_mode    <= cfg_data[0];
                REG_SCALE_FMT: cfg_reg.scale_format      <= cfg_data[1:0];
                REG_ACT_FMT:   cfg_reg.activation_format <= cfg_data[1:0];
                REG_OUT_FMT:   cfg_reg.output_format     <= cfg_data[1:0];
                default:       ;
            endcase
        end
    end

    gqdp_decode u_decode
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .cfg            (cfg_reg),
        .in_valid       (s_tvalid),
        .code           (s_tdata[7:0]),
        .scale_raw      (s_tdata[23:8]),
        .bias_raw       (s_tdata[39:24]),
        .activation_raw (s_tdata[71:40]),
        .last_in        (s_tlast),
        .dec_valid      (dec_valid),
        .dec            (dec)
    );

    gqdp_weight u_weight
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .symmetric_mode (cfg_reg.symmetric_mode),
        .dec_valid      (dec_valid),
        .dec            (dec),
        .prod_valid     (prod_valid),
        .prod           (prod),
        .prod_last      (prod_last)
    );

    gqdp_accum #(
        .ACCUM_LANES (ACCUM_LANES)
    ) u_accum
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .output_format (cfg_reg.output_format),
        .prod_valid    (prod_valid),
        .prod          (prod),
        .prod_last     (prod_last),
        .out_valid     (pipe_valid),
        .out_data      (pipe_data)
    );

    // output register, frees the pipeline while a result waits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_free)
            res_valid_reg <= pipe_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_free)
            res_data_reg <= pipe_data;
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata = res_data_reg;

endmodule

// ===== src/gqdp_decode.sv =====
// ----------------------------------------------------------------------------
// gqdp_decode
// first stage: code, scale, bias and activation words unpacked to fp32
// ----------------------------------------------------------------------------
module gqdp_decode
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  gqdp_pkg::cfg_t     cfg,
    input  logic               in_valid,
    input  logic [7:0]         code,
    input  logic [15:0]        scale_raw,
    input  logic [15:0]        bias_raw,
    input  logic [31:0]        activation_raw,
    input  logic               last_in,
    output logic               dec_valid,
    output gqdp_pkg::dec_t     dec
);
    import gqdp_pkg::*;

    logic [3:0]        bits;
    logic [7:0]        code_m;
    logic [8:0]        mid;
    logic signed [8:0] cval;
    logic              valid_reg;
    dec_t              dec_reg;
    dec_t              dec_next;

    always_comb
    begin
        if (cfg.code_bits < 4'd2)
            bits = 4'd2;
        else if (cfg.code_bits > 4'd8)
            bits = 4'd8;
        else
            bits = cfg.code_bits;
        code_m = code & 8'((9'd1 << bits) - 9'd1);
        mid = 9'd1 << (bits - 4'd1);
        if (cfg.symmetric_mode)
            cval = $signed({1'b0, code_m}) - $signed(mid);
        else
            cval = $signed({1'b0, code_m});
        dec_next.cval  = code_to_f(cval);
        dec_next.scale = decode_scale(cfg.scale_format, scale_raw);
        dec_next.bias  = decode_scale(cfg.scale_format, bias_raw);
        dec_next.act   = decode_act(cfg.activation_format, activation_raw);
        dec_next.last  = last_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            dec_reg <= dec_next;
    end

    assign dec_valid = valid_reg;
    assign dec = dec_reg;

endmodule

// ===== src/gqdp_weight.sv =====
// ----------------------------------------------------------------------------
// gqdp_weight
// three stages: code times scale, bias add, weight times activation
// ----------------------------------------------------------------------------
module gqdp_weight
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           symmetric_mode,
    input  logic           dec_valid,
    input  gqdp_pkg::dec_t dec,
    output logic           prod_valid,
    output logic [31:0]    prod,
    output logic           prod_last
);
    import gqdp_pkg::*;

    logic        v2_reg;
    logic        v3_reg;
    logic        v4_reg;
    logic [31:0] p1_reg;
    logic [31:0] bias2_reg;
    logic [31:0] act2_reg;
    logic        last2_reg;
    logic [31:0] w3_reg;
    logic [31:0] w3_next;
    logic [31:0] act3_reg;
    logic        last3_reg;
    logic [31:0] p4_reg;
    logic        last4_reg;

    assign w3_next = symmetric_mode ? p1_reg : fp_add(p1_reg, bias2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= dec_valid;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg    <= fp_mul(dec.cval, dec.scale);
            bias2_reg <= dec.bias;
            act2_reg  <= dec.act;
            last2_reg <= dec.last;
            w3_reg    <= w3_next;
            act3_reg  <= act2_reg;
            last3_reg <= last2_reg;
            p4_reg    <= fp_mul(w3_reg, act3_reg);
            last4_reg <= last3_reg;
        end
    end

    assign prod_valid = v4_reg;
    assign prod = p4_reg;
    assign prod_last = last4_reg;

endmodule

// ===== src/gqdp_accum.sv =====
// ----------------------------------------------------------------------------
// gqdp_accum
// interleaved fp32 partial sums, registered pairwise reduction, output encode
// ----------------------------------------------------------------------------
module gqdp_accum
#(
    parameter int ACCUM_LANES = gqdp_pkg::ACCUM_LANES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic [1:0]  output_format,
    input  logic        prod_valid,
    input  logic [31:0] prod,
    input  logic        prod_last,
    output logic        out_valid,
    output logic [31:0] out_data
);
    import gqdp_pkg::*;

    localparam int LANE_W = (ACCUM_LANES > 1) ? $clog2(ACCUM_LANES) : 1;
    localparam int LEVELS = $clog2(ACCUM_LANES);

    logic [31:0]       ps_reg [ACCUM_LANES];
    logic [LANE_W-1:0] lane_reg;
    logic [31:0]       sel;
    logic [31:0]       sum;
    logic [31:0]       lvl_reg [LEVELS+1][ACCUM_LANES];
    logic              lvl_v_reg [LEVELS+1];
    logic              out_valid_reg;
    logic [31:0]       out_data_reg;

    always_comb
    begin
        sel = '0;
        for (int i = 0; i < ACCUM_LANES; i++)
        begin
            if (lane_reg == LANE_W'(i))
                sel = ps_reg[i];
        end
        sum = fp_add(sel, prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ACCUM_LANES; i++)
                ps_reg[i] <= '0;
            lane_reg <= '0;
        end
        else if (adv && prod_valid)
        begin
            if (prod_last)
            begin
                for (int i = 0; i < ACCUM_LANES; i++)
                    ps_reg[i] <= '0;
                lane_reg <= '0;
            end
            else
            begin
                for (int i = 0; i < ACCUM_LANES; i++)
                begin
                    if (lane_reg == LANE_W'(i))
                        ps_reg[i] <= sum;
                end
                if (lane_reg == LANE_W'(ACCUM_LANES - 1))
                    lane_reg <= '0;
                else
                    lane_reg <= lane_reg + LANE_W'(1);
            end
        end
    end

    // row totals snapshot into the first reduction level
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < ACCUM_LANES; i++)
                lvl_reg[0][i] <= (lane_reg == LANE_W'(i)) ? sum : ps_reg[i];
        end
    end

    for (genvar k = 1; k <= LEVELS; k++)
    begin : g_level
        localparam int NP = level_count(ACCUM_LANES, k - 1);
        for (genvar i = 0; i < NP / 2; i++)
        begin : g_pair
            always_ff @(posedge clk)
            begin
                if (adv)
                    lvl_reg[k][i] <= fp_add(lvl_reg[k-1][2*i], lvl_reg[k-1][2*i+1]);
            end
        end
        if (NP % 2 == 1)
        begin : g_odd
            always_ff @(posedge clk)
            begin
                if (adv)
                    lvl_reg[k][NP/2] <= lvl_reg[k-1][NP-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LEVELS; k++)
                lvl_v_reg[k] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            lvl_v_reg[0] <= prod_valid && prod_last;
            for (int k = 1; k <= LEVELS; k++)
                lvl_v_reg[k] <= lvl_v_reg[k-1];
            out_valid_reg <= lvl_v_reg[LEVELS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= encode_out(output_format, lvl_reg[LEVELS][0]);
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

endmodule

// ===== src/gqdp_checker.sv =====
// ----------------------------------------------------------------------------
// gqdp_checker
// port-level checks on flow control of the dot product block
// ----------------------------------------------------------------------------
module gqdp_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gqdp_pkg::M_DATA_W-1:0] m_tdata
);
    // the input side only stalls while a result is refused
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("s_tready low without a refused result");

    // a new result only appears on a cycle the pipeline moved
    a_result_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tready))
        else $error("result appeared while pipeline was held");

    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped before transaction");

    a_data_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

endmodule

bind grouped_quant_dot_product gqdp_checker u_gqdp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
